>>> rtl/wss_pkg.sv
// Shared types, constants and helper functions for the waypoint steering block.
package wss_pkg;

	localparam int WP_DEPTH = 64;
	localparam int WP_AW    = $clog2(WP_DEPTH);
	localparam int IDX_W    = 7;

	localparam logic [63:0] DIST2_MIN  = 64'd4295;
	localparam logic [30:0] ACCEL_MIN  = 31'd65;
	localparam logic [30:0] WORK_R_MIN = 31'd49152;
	localparam logic [16:0] TS_MAX     = 17'd65536;
	localparam logic [1:0]  COMP_LAST  = 2'd2;

	localparam logic [30:0] MAX_SPEED_RST = 31'd655360;
	localparam logic [30:0] MAX_ACCEL_RST = 31'd327680;
	localparam logic [30:0] ARR_RAD_RST   = 31'd65536;
	localparam logic [16:0] TIME_STEP_RST = 17'd1092;

	typedef enum logic [1:0] {
		OPC_LOAD    = 2'd0,
		OPC_RESTART = 2'd1,
		OPC_TICK    = 2'd2,
		OPC_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_MAX_SPEED = 2'd0,
		REG_MAX_ACCEL = 2'd1,
		REG_ARR_RAD   = 2'd2,
		REG_TIME_STEP = 2'd3
	} cfg_reg_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_ACCEPT, OP_FETCH, OP_LOAD, OP_MUL, OP_ACC, OP_DOT, OP_D2_CHK,
		OP_SET_WANT, OP_WANT_MIN, OP_SQRT_ACC, OP_SQRT_PROD2, OP_DIV_DIST,
		OP_DIV_LEN, OP_DL_Q, OP_SET_MAXD, OP_SET_LEN, OP_DL_SCALE, OP_VADD,
		OP_VW_SCALE, OP_POS, OP_ARRIVE, OP_RESP
	} dp_op_t;

	typedef enum logic [3:0] {
		M_BEF_SQ, M_DL_SQ, M_VW_SQ, M_AFT_SQ, M_BEF_AFT, M_BEF_WANT, M_ACC_DIST,
		M_ACC_TS, M_MAXD_SQ, M_DL_MAXD, M_MS_SQ, M_VW_MS, M_VW_TS, M_R_SQ
	} mul_sel_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_FETCH, ST_LOAD, ST_D2_M, ST_D2_A, ST_D2_CHK, ST_D_W, ST_WANT,
		ST_BRK_M, ST_BRK_S, ST_BRK_W, ST_BRK_MIN, ST_DL_M, ST_DL_D, ST_DL_W, ST_DL_Q,
		ST_MD_M, ST_MD_S, ST_L2_M, ST_L2_A, ST_L2_PM, ST_L2_CHK, ST_L2_W, ST_L2_LEN,
		ST_DLS_M, ST_DLS_D, ST_DLS_W, ST_DLS_Q, ST_VADD, ST_V2_M, ST_V2_A, ST_V2_PM,
		ST_V2_CHK, ST_V2_W, ST_V2_LEN, ST_VS_M, ST_VS_D, ST_VS_W, ST_VS_Q, ST_POS_M,
		ST_POS_U, ST_A2_M, ST_A2_A, ST_DOT_M, ST_DOT_A, ST_R_M, ST_ARR, ST_RESP
	} ctl_state_t;

	typedef struct packed {
		dp_op_t     op;
		mul_sel_t   msel;
		logic [1:0] comp;
	} dp_cmd_t;

	typedef struct packed {
		logic no_path;
		logic acc_small;
		logic acc_gt_prod;
		logic work;
		logic accel_small;
		logic ts_zero;
		logic sqrt_done;
		logic div_done;
	} dp_sts_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [IDX_W-1:0]   slot;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic               point_kind;
	} item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [IDX_W-1:0]   target_index;
		logic               arrived;
	} res_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               kind;
	} wp_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -34'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

	function automatic logic signed [33:0] sext34(input logic signed [31:0] v);
		return $signed({{2{v[31]}}, v});
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	function automatic logic signed [33:0] apply_sign(input logic [31:0] m, input logic neg);
		logic signed [33:0] t;
		t = $signed({2'b00, m});
		return neg ? -t : t;
	endfunction

endpackage

>>> rtl/wss_ifs.sv
// Handshake interfaces for the item, result and configuration channels.
interface wss_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [6:0]         slot;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic               point_kind;

	modport source (output valid, op, slot, coord_x, coord_y, coord_z, point_kind,
		input ready);
	modport sink (input valid, op, slot, coord_x, coord_y, coord_z, point_kind,
		output ready);
endinterface

interface wss_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_z;
	logic [6:0]         target_index;
	logic               arrived;

	modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		target_index, arrived, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		target_index, arrived, output ready);
endinterface

interface wss_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/wss_sqrt.sv
// Iterative floor square root of a 64-bit value, two radicand bits per cycle.
module wss_sqrt import wss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] operand,
	output logic        done,
	output logic [31:0] root
);
	localparam int STEPS = 32;
	localparam int CNT_W = $clog2(STEPS);

	logic [63:0]      x_q;
	logic [33:0]      rem_q;
	logic [31:0]      root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [35:0]      rem_sh;
	logic [35:0]      trial;
	logic             fits;

	assign rem_sh = {rem_q, x_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[61:0], 2'b00};
			rem_q  <= fits ? 34'(rem_sh - trial) : rem_sh[33:0];
			root_q <= {root_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

>>> rtl/wss_div.sv
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module wss_div import wss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	localparam int STEPS = 64;
	localparam int CNT_W = $clog2(STEPS);

	logic [63:0]      n_q;
	logic [31:0]      d_q;
	logic [31:0]      rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [32:0]      rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, n_q[63]};
	assign fits   = rem_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			d_q   <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(rem_sh - {1'b0, d_q}) : rem_sh[31:0];
			n_q   <= {n_q[62:0], fits};
		end
	end

	// quotients here are always below 2^31
	assign done     = done_q;
	assign quotient = n_q[31:0];
endmodule

>>> rtl/wss_dp.sv
// Datapath: craft state, waypoint memory, shared multiplier, square root and divider.
module wss_dp import wss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  item_t       item,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output res_t        res
);
	logic [30:0] ms_q, ma_q, ar_q;
	logic [16:0] ts_q;

	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic [IDX_W-1:0]   idx_q, plen_q;

	wp_t mem [WP_DEPTH];
	wp_t rd_q;

	logic signed [31:0] wp_q [3];
	logic signed [31:0] bef_q [3];
	logic signed [31:0] vw_q [3];
	logic signed [31:0] dl_q [3];
	logic signed [31:0] aft_q [3];
	logic               work_q;
	logic [63:0]        prod_q, acc_q, dpos_q, dneg_q, d2b_q;
	logic               prod_neg_q;
	logic [31:0]        dist_q, len_q;
	logic [30:0]        want_q, maxd_q;
	res_t               res_q;

	logic [1:0]  c;
	logic [31:0] mul_a, mul_b;
	logic [30:0] r_sel;
	logic        sqrt_start, sqrt_done, div_start, div_done;
	logic [63:0] sqrt_in;
	logic [31:0] sqrt_root, div_den, div_q;
	logic        near, passed, work_hit, tr_hit;
	logic [IDX_W-1:0] idx_nx;
	logic signed [31:0] np;

	assign c = cmd.comp;

	// arrival radius, floored for work points
	assign r_sel = (work_q && ar_q < WORK_R_MIN) ? WORK_R_MIN : ar_q;

	always_comb begin
		mul_a = mag32(bef_q[c]);
		mul_b = mag32(bef_q[c]);
		case (cmd.msel)
			M_BEF_SQ:   begin mul_a = mag32(bef_q[c]); mul_b = mag32(bef_q[c]); end
			M_DL_SQ:    begin mul_a = mag32(dl_q[c]);  mul_b = mag32(dl_q[c]);  end
			M_VW_SQ:    begin mul_a = mag32(vw_q[c]);  mul_b = mag32(vw_q[c]);  end
			M_AFT_SQ:   begin mul_a = mag32(aft_q[c]); mul_b = mag32(aft_q[c]); end
			M_BEF_AFT:  begin mul_a = mag32(bef_q[c]); mul_b = mag32(aft_q[c]); end
			M_BEF_WANT: begin mul_a = mag32(bef_q[c]); mul_b = {1'b0, want_q};  end
			M_ACC_DIST: begin mul_a = {1'b0, ma_q};    mul_b = dist_q;          end
			M_ACC_TS:   begin mul_a = {1'b0, ma_q};    mul_b = {15'd0, ts_q};   end
			M_MAXD_SQ:  begin mul_a = {1'b0, maxd_q};  mul_b = {1'b0, maxd_q};  end
			M_DL_MAXD:  begin mul_a = mag32(dl_q[c]);  mul_b = {1'b0, maxd_q};  end
			M_MS_SQ:    begin mul_a = {1'b0, ms_q};    mul_b = {1'b0, ms_q};    end
			M_VW_MS:    begin mul_a = mag32(vw_q[c]);  mul_b = {1'b0, ms_q};    end
			M_VW_TS:    begin mul_a = mag32(vw_q[c]);  mul_b = {15'd0, ts_q};   end
			M_R_SQ:     begin mul_a = {1'b0, r_sel};   mul_b = {1'b0, r_sel};   end
			default:    begin mul_a = '0;              mul_b = '0;              end
		endcase
	end

	assign sqrt_start = (cmd.op == OP_D2_CHK && !sts.acc_small && !sts.ts_zero) ||
		cmd.op == OP_SQRT_ACC || cmd.op == OP_SQRT_PROD2;
	assign sqrt_in    = (cmd.op == OP_SQRT_PROD2) ? {prod_q[62:0], 1'b0} : acc_q;
	assign div_start  = cmd.op == OP_DIV_DIST || cmd.op == OP_DIV_LEN;
	assign div_den    = (cmd.op == OP_DIV_LEN) ? len_q : dist_q;

	wss_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .operand(sqrt_in),
		.done(sqrt_done), .root(sqrt_root)
	);

	wss_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(prod_q),
		.divisor(div_den), .done(div_done), .quotient(div_q)
	);

	// arrival tests; acc holds the squared distance after the move
	assign near     = acc_q <= prod_q;
	assign passed   = dpos_q <= dneg_q;
	assign work_hit = near || (passed && d2b_q <= {prod_q[61:0], 2'b00});
	assign tr_hit   = near || passed;
	assign idx_nx   = idx_q + 1'b1;
	assign np       = sat32(sext34(pos_q[c]) + apply_sign(prod_q[47:16], vw_q[c][31]));

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACCEPT && item.op == OPC_LOAD && item.slot < IDX_W'(WP_DEPTH)) begin
			mem[item.slot[WP_AW-1:0]] <= '{x: item.coord_x, y: item.coord_y,
				z: item.coord_z, kind: item.point_kind};
		end
		if (cmd.op == OP_FETCH) begin
			rd_q <= mem[idx_q[WP_AW-1:0]];
		end
	end

	// architectural state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q   <= MAX_SPEED_RST;
			ma_q   <= MAX_ACCEL_RST;
			ar_q   <= ARR_RAD_RST;
			ts_q   <= TIME_STEP_RST;
			idx_q  <= '0;
			plen_q <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_SPEED: ms_q <= cfg_data[30:0];
					REG_MAX_ACCEL: ma_q <= cfg_data[30:0];
					REG_ARR_RAD:   ar_q <= cfg_data[30:0];
					REG_TIME_STEP: ts_q <= (cfg_data[16:0] > TS_MAX) ? TS_MAX : cfg_data[16:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_ACCEPT: begin
					if (item.op == OPC_RESTART) begin
						pos_q[0] <= item.coord_x;
						pos_q[1] <= item.coord_y;
						pos_q[2] <= item.coord_z;
						for (int i = 0; i < 3; i++) vel_q[i] <= '0;
						idx_q  <= '0;
						plen_q <= (item.slot > IDX_W'(WP_DEPTH)) ? IDX_W'(WP_DEPTH) : item.slot;
					end
				end
				OP_POS: pos_q[c] <= np;
				OP_ARRIVE: begin
					if (work_q) begin
						if (work_hit) begin
							for (int i = 0; i < 3; i++) begin
								pos_q[i] <= wp_q[i];
								vel_q[i] <= '0;
							end
							idx_q <= idx_nx;
						end else begin
							for (int i = 0; i < 3; i++) vel_q[i] <= vw_q[i];
						end
					end else begin
						for (int i = 0; i < 3; i++) begin
							vel_q[i] <= (tr_hit && idx_nx >= plen_q) ? '0 : vw_q[i];
						end
						if (tr_hit) idx_q <= idx_nx;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers of one tick
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				wp_q[0] <= rd_q.x;
				wp_q[1] <= rd_q.y;
				wp_q[2] <= rd_q.z;
				work_q  <= rd_q.kind;
				bef_q[0] <= sat32(sext34(rd_q.x) - sext34(pos_q[0]));
				bef_q[1] <= sat32(sext34(rd_q.y) - sext34(pos_q[1]));
				bef_q[2] <= sat32(sext34(rd_q.z) - sext34(pos_q[2]));
				for (int i = 0; i < 3; i++) vw_q[i] <= vel_q[i];
			end
			OP_MUL: begin
				prod_q     <= {32'd0, mul_a} * {32'd0, mul_b};
				prod_neg_q <= bef_q[c][31] ^ aft_q[c][31];
			end
			OP_ACC: acc_q <= ((c == 2'd0) ? 64'd0 : acc_q) + prod_q;
			OP_DOT: begin
				if (prod_neg_q) begin
					dneg_q <= ((c == 2'd0) ? 64'd0 : dneg_q) + prod_q;
					if (c == 2'd0) dpos_q <= '0;
				end else begin
					dpos_q <= ((c == 2'd0) ? 64'd0 : dpos_q) + prod_q;
					if (c == 2'd0) dneg_q <= '0;
				end
			end
			OP_D2_CHK: begin
				d2b_q <= acc_q;
				// a zero time step leaves the velocity alone
				if (sts.acc_small && !sts.ts_zero) begin
					for (int i = 0; i < 3; i++) vw_q[i] <= '0;
				end
			end
			OP_SET_WANT: begin
				dist_q <= sqrt_root;
				want_q <= (work_q && sts.accel_small) ? 31'd0 : ms_q;
			end
			OP_WANT_MIN: if (sqrt_root < {1'b0, want_q}) want_q <= sqrt_root[30:0];
			OP_DL_Q: dl_q[c] <= sat32(apply_sign(div_q, bef_q[c][31]) - sext34(vw_q[c]));
			OP_SET_MAXD: maxd_q <= prod_q[46:16];
			OP_SET_LEN: len_q <= sqrt_root;
			OP_DL_SCALE: dl_q[c] <= 32'(apply_sign(div_q, dl_q[c][31]));
			OP_VADD: begin
				for (int i = 0; i < 3; i++) vw_q[i] <= sat32(sext34(vw_q[i]) + sext34(dl_q[i]));
			end
			OP_VW_SCALE: vw_q[c] <= 32'(apply_sign(div_q, vw_q[c][31]));
			OP_POS: aft_q[c] <= sat32(sext34(wp_q[c]) - sext34(np));
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_RESP) begin
			res_q.pos_x        <= pos_q[0];
			res_q.pos_y        <= pos_q[1];
			res_q.pos_z        <= pos_q[2];
			res_q.vel_x        <= vel_q[0];
			res_q.vel_y        <= vel_q[1];
			res_q.vel_z        <= vel_q[2];
			res_q.target_index <= idx_q;
			res_q.arrived      <= idx_q >= plen_q;
		end
	end

	assign res = res_q;

	assign sts.no_path     = idx_q >= plen_q;
	assign sts.acc_small   = acc_q < DIST2_MIN;
	assign sts.acc_gt_prod = acc_q > prod_q;
	assign sts.work        = work_q;
	assign sts.accel_small = ma_q <= ACCEL_MIN;
	assign sts.ts_zero     = ts_q == '0;
	assign sts.sqrt_done   = sqrt_done;
	assign sts.div_done    = div_done;
endmodule

>>> rtl/wss_ctrl.sv
// Controller: sequences one request through the datapath and runs both handshakes.
module wss_ctrl import wss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic [1:0] item_op,
	output logic       item_ready,
	output logic       res_valid,
	input  logic       res_ready,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd
);
	ctl_state_t state_q, state_d;
	logic [1:0] c_q, c_d;
	logic       out_valid_q;
	logic       accept, resp_go;

	assign accept  = state_q == ST_IDLE && item_valid;
	assign resp_go = state_q == ST_RESP && (!out_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			c_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			c_q     <= c_d;
			if (resp_go) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		c_d     = c_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (item_op == OPC_TICK && !sts.no_path) ? ST_FETCH : ST_RESP;
				end
			end
			ST_FETCH:  state_d = ST_LOAD;
			// squared distance is always needed for the work point overshoot test
			ST_LOAD:   state_d = ST_D2_M;
			ST_D2_M:   state_d = ST_D2_A;
			ST_D2_A: begin
				if (c_q == COMP_LAST) begin state_d = ST_D2_CHK; c_d = '0; end
				else begin state_d = ST_D2_M; c_d = c_q + 1'b1; end
			end
			ST_D2_CHK: state_d = (sts.acc_small || sts.ts_zero) ? ST_POS_M : ST_D_W;
			ST_D_W:    if (sts.sqrt_done) state_d = ST_WANT;
			ST_WANT:   state_d = (sts.work && !sts.accel_small) ? ST_BRK_M : ST_DL_M;
			ST_BRK_M:  state_d = ST_BRK_S;
			ST_BRK_S:  state_d = ST_BRK_W;
			ST_BRK_W:  if (sts.sqrt_done) state_d = ST_BRK_MIN;
			ST_BRK_MIN: state_d = ST_DL_M;
			ST_DL_M:   state_d = ST_DL_D;
			ST_DL_D:   state_d = ST_DL_W;
			ST_DL_W:   if (sts.div_done) state_d = ST_DL_Q;
			ST_DL_Q: begin
				if (c_q == COMP_LAST) begin state_d = ST_MD_M; c_d = '0; end
				else begin state_d = ST_DL_M; c_d = c_q + 1'b1; end
			end
			ST_MD_M:   state_d = ST_MD_S;
			ST_MD_S:   state_d = ST_L2_M;
			ST_L2_M:   state_d = ST_L2_A;
			ST_L2_A: begin
				if (c_q == COMP_LAST) begin state_d = ST_L2_PM; c_d = '0; end
				else begin state_d = ST_L2_M; c_d = c_q + 1'b1; end
			end
			ST_L2_PM:  state_d = ST_L2_CHK;
			ST_L2_CHK: state_d = sts.acc_gt_prod ? ST_L2_W : ST_VADD;
			ST_L2_W:   if (sts.sqrt_done) state_d = ST_L2_LEN;
			ST_L2_LEN: state_d = ST_DLS_M;
			ST_DLS_M:  state_d = ST_DLS_D;
			ST_DLS_D:  state_d = ST_DLS_W;
			ST_DLS_W:  if (sts.div_done) state_d = ST_DLS_Q;
			ST_DLS_Q: begin
				if (c_q == COMP_LAST) begin state_d = ST_VADD; c_d = '0; end
				else begin state_d = ST_DLS_M; c_d = c_q + 1'b1; end
			end
			ST_VADD:   state_d = ST_V2_M;
			ST_V2_M:   state_d = ST_V2_A;
			ST_V2_A: begin
				if (c_q == COMP_LAST) begin state_d = ST_V2_PM; c_d = '0; end
				else begin state_d = ST_V2_M; c_d = c_q + 1'b1; end
			end
			ST_V2_PM:  state_d = ST_V2_CHK;
			ST_V2_CHK: state_d = sts.acc_gt_prod ? ST_V2_W : ST_POS_M;
			ST_V2_W:   if (sts.sqrt_done) state_d = ST_V2_LEN;
			ST_V2_LEN: state_d = ST_VS_M;
			ST_VS_M:   state_d = ST_VS_D;
			ST_VS_D:   state_d = ST_VS_W;
			ST_VS_W:   if (sts.div_done) state_d = ST_VS_Q;
			ST_VS_Q: begin
				if (c_q == COMP_LAST) begin state_d = ST_POS_M; c_d = '0; end
				else begin state_d = ST_VS_M; c_d = c_q + 1'b1; end
			end
			ST_POS_M:  state_d = ST_POS_U;
			ST_POS_U: begin
				if (c_q == COMP_LAST) begin state_d = ST_A2_M; c_d = '0; end
				else begin state_d = ST_POS_M; c_d = c_q + 1'b1; end
			end
			ST_A2_M:   state_d = ST_A2_A;
			ST_A2_A: begin
				if (c_q == COMP_LAST) begin state_d = ST_DOT_M; c_d = '0; end
				else begin state_d = ST_A2_M; c_d = c_q + 1'b1; end
			end
			ST_DOT_M:  state_d = ST_DOT_A;
			ST_DOT_A: begin
				if (c_q == COMP_LAST) begin state_d = ST_R_M; c_d = '0; end
				else begin state_d = ST_DOT_M; c_d = c_q + 1'b1; end
			end
			ST_R_M:    state_d = ST_ARR;
			ST_ARR:    state_d = ST_RESP;
			ST_RESP:   if (resp_go) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.msel = M_BEF_SQ;
		cmd.comp = c_q;
		case (state_q)
			ST_IDLE:    if (accept) cmd.op = OP_ACCEPT;
			ST_FETCH:   cmd.op = OP_FETCH;
			ST_LOAD:    cmd.op = OP_LOAD;
			ST_D2_M:    begin cmd.op = OP_MUL; cmd.msel = M_BEF_SQ; end
			ST_D2_A:    cmd.op = OP_ACC;
			ST_D2_CHK:  cmd.op = OP_D2_CHK;
			ST_WANT:    cmd.op = OP_SET_WANT;
			ST_BRK_M:   begin cmd.op = OP_MUL; cmd.msel = M_ACC_DIST; end
			ST_BRK_S:   cmd.op = OP_SQRT_PROD2;
			ST_BRK_MIN: cmd.op = OP_WANT_MIN;
			ST_DL_M:    begin cmd.op = OP_MUL; cmd.msel = M_BEF_WANT; end
			ST_DL_D:    cmd.op = OP_DIV_DIST;
			ST_DL_Q:    cmd.op = OP_DL_Q;
			ST_MD_M:    begin cmd.op = OP_MUL; cmd.msel = M_ACC_TS; end
			ST_MD_S:    cmd.op = OP_SET_MAXD;
			ST_L2_M:    begin cmd.op = OP_MUL; cmd.msel = M_DL_SQ; end
			ST_L2_A:    cmd.op = OP_ACC;
			ST_L2_PM:   begin cmd.op = OP_MUL; cmd.msel = M_MAXD_SQ; end
			ST_L2_CHK:  if (sts.acc_gt_prod) cmd.op = OP_SQRT_ACC;
			ST_L2_LEN:  cmd.op = OP_SET_LEN;
			ST_DLS_M:   begin cmd.op = OP_MUL; cmd.msel = M_DL_MAXD; end
			ST_DLS_D:   cmd.op = OP_DIV_LEN;
			ST_DLS_Q:   cmd.op = OP_DL_SCALE;
			ST_VADD:    cmd.op = OP_VADD;
			ST_V2_M:    begin cmd.op = OP_MUL; cmd.msel = M_VW_SQ; end
			ST_V2_A:    cmd.op = OP_ACC;
			ST_V2_PM:   begin cmd.op = OP_MUL; cmd.msel = M_MS_SQ; end
			ST_V2_CHK:  if (sts.acc_gt_prod) cmd.op = OP_SQRT_ACC;
			ST_V2_LEN:  cmd.op = OP_SET_LEN;
			ST_VS_M:    begin cmd.op = OP_MUL; cmd.msel = M_VW_MS; end
			ST_VS_D:    cmd.op = OP_DIV_LEN;
			ST_VS_Q:    cmd.op = OP_VW_SCALE;
			ST_POS_M:   begin cmd.op = OP_MUL; cmd.msel = M_VW_TS; end
			ST_POS_U:   cmd.op = OP_POS;
			ST_A2_M:    begin cmd.op = OP_MUL; cmd.msel = M_AFT_SQ; end
			ST_A2_A:    cmd.op = OP_ACC;
			ST_DOT_M:   begin cmd.op = OP_MUL; cmd.msel = M_BEF_AFT; end
			ST_DOT_A:   cmd.op = OP_DOT;
			ST_R_M:     begin cmd.op = OP_MUL; cmd.msel = M_R_SQ; end
			ST_ARR:     cmd.op = OP_ARRIVE;
			ST_RESP:    if (resp_go) cmd.op = OP_RESP;
			default:    cmd.op = OP_NONE;
		endcase
	end

	assign item_ready = state_q == ST_IDLE;
	assign res_valid  = out_valid_q;
endmodule

>>> rtl/waypoint_steering_step.sv
// Acceleration-limited waypoint steering, Q16.16: one request in, one result out.
// Load and restart requests, ticks with no path left and the unused opcode go straight
// from the accept to the result load. A tick runs through one shared 32x32 multiplier,
// an iterative square root (2 radicand bits per cycle) and a restoring divider (one
// quotient bit per cycle). A zero time step or a craft already on the point skips the
// roots and divisions. The longest ticks are those in which braking, the velocity step
// limit and the speed limit all engage (four roots and nine divisions). A new request is
// taken once the previous one has been written to the result register, while that
// result still waits to be taken.
// Configuration writes are taken every cycle and must only be issued while idle.
module waypoint_steering_step import wss_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	wss_item_if.sink     item,
	wss_result_if.source result,
	wss_cfg_if.sink      cfg
);
	dp_cmd_t cmd;
	dp_sts_t sts;
	item_t   item_pl;
	res_t    res_pl;

	assign item_pl.op         = item.op;
	assign item_pl.slot       = item.slot;
	assign item_pl.coord_x    = item.coord_x;
	assign item_pl.coord_y    = item.coord_y;
	assign item_pl.coord_z    = item.coord_z;
	assign item_pl.point_kind = item.point_kind;

	// configuration registers sit in the datapath and take a write at once
	assign cfg.ready = 1'b1;

	wss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_op    (item.op),
		.item_ready (item.ready),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	wss_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item_pl),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.res       (res_pl)
	);

	assign result.pos_x        = res_pl.pos_x;
	assign result.pos_y        = res_pl.pos_y;
	assign result.pos_z        = res_pl.pos_z;
	assign result.vel_x        = res_pl.vel_x;
	assign result.vel_y        = res_pl.vel_y;
	assign result.vel_z        = res_pl.vel_z;
	assign result.target_index = res_pl.target_index;
	assign result.arrived      = res_pl.arrived;

	// one request at a time: after taking a request the block drops ready
	assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("request taken while the previous one is in flight");

	// the result register is only loaded when it is free or being drained
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_RESP |-> (!result.valid || result.ready))
		else $error("result overwritten before it was taken");

	// a result appears only after a result load
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.op == OP_RESP))
		else $error("result valid without a result load");

	// the accept command is issued only on a completed input handshake
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_ACCEPT |-> item.valid && item.ready)
		else $error("request applied without a handshake");
endmodule
